@@ rtl/core/awsf_pkg.sv @@
// types and constants shared by the window statistics block
// no dependencies
package awsf_pkg;

	localparam int LEN_W = 9;   // effective window length, up to 256
	localparam int SUM_W = 25;  // signed running z sum
	localparam int ACC_W = 41;  // squared-deviation and abs-deviation sums
	localparam int WL_RESET = 64;
	localparam logic [14:0] SAT15 = 15'h7fff;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [14:0]        variance_z;
		logic [14:0]        mean_abs_dev_z;
		logic signed [15:0] min_y;
		logic [14:0]        range_x;
		logic [14:0]        range_y;
		logic [14:0]        range_z;
	} result_t;

	// one finished window handed from front to back
	typedef struct packed {
		logic                    bank;
		logic [LEN_W-1:0]        len;
		logic signed [SUM_W-1:0] sum;
		logic signed [15:0]      min_y;
		logic [14:0]             range_x;
		logic [14:0]             range_y;
		logic [14:0]             range_z;
	} job_t;

endpackage

@@ rtl/core/accel_window_stat_features.sv @@
// top level: accelerometer window statistics, front intake plus back finish
// uses awsf_pkg, awsf_ram, awsf_front, awsf_back
//
//  channel   handshake             payload
//  sample    start / busy          sample   (sample_t)
//  result    result_valid strobe   result   (result_t)
//  config    cfg_we                cfg_data (window length)
//
// a sample is taken whenever start is high and busy is low; busy is high for the cycle after each window
// closes, and stays high while the previous window is still being finished,
// since the z store holds only two banks.
// after the sample that closes a window, the result strobe follows the job hand-off and
// three bit-serial divisions (mean, variance, deviation), with the store read sweep
// between the mean and the variance division.
// after reset the window length is 64; no clearing pass is needed.
// the result strobe is high for one cycle only; the receiver cannot stall it.
module accel_window_stat_features import awsf_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  sample_t sample,
	input  logic    cfg_we,
	input  logic [7:0] cfg_data,
	output result_t result,
	output logic    result_valid
);

	localparam int AW = $clog2(MAX_WINDOW);

	logic          ram_we;
	logic [AW:0]   ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;
	logic          job_valid, back_ready;
	job_t          job;

	awsf_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sample     (sample),
		.busy       (busy),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.job_valid  (job_valid),
		.job        (job),
		.back_ready (back_ready)
	);

	awsf_ram #(.WIDTH(16), .DEPTH(2 * MAX_WINDOW)) u_zram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	awsf_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.ready        (back_ready),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

@@ rtl/core/awsf_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module awsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/awsf_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// uses awsf_pkg
module awsf_div import awsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [ACC_W-1:0] dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic             done,
	output logic [ACC_W-1:0] quotient
);

	localparam int CW = $clog2(ACC_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             act_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dsr_q;
	logic [LEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quotient[ACC_W-1]};
	assign fits = rem_sh >= {1'b0, dsr_q};

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			act_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				act_q <= 1'b1;
				cnt_q <= CW'(ACC_W);
			end else if (act_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					act_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			quotient <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (act_q) begin
			if (fits) begin
				rem_q <= LEN_W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[LEN_W-1:0];
			end
			quotient <= {quotient[ACC_W-2:0], fits};
		end
	end

endmodule

@@ rtl/core/awsf_front.sv @@
// sample intake: running extremes, z sum, z store writes, one-entry job queue
// uses awsf_pkg
module awsf_front import awsf_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sample_t                       sample,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_data,
	output logic                          ram_we,
	output logic [$clog2(MAX_WINDOW):0]   ram_waddr,
	output logic [15:0]                   ram_wdata,
	output logic                          job_valid,
	output job_t                          job,
	input  logic                          back_ready
);

	localparam int AW = $clog2(MAX_WINDOW);

	logic [7:0]              wlen_q;
	logic [LEN_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    wbank_q;
	logic signed [15:0]      mnx_q, mxx_q, mny_q, mxy_q, mnz_q, mxz_q;
	logic signed [15:0]      mnx_n, mxx_n, mny_n, mxy_n, mnz_n, mxz_n;
	logic [LEN_W-1:0]        eff_len, cnt_n;
	logic signed [SUM_W-1:0] sum_n;
	logic                    take, first, last;

	function automatic logic [14:0] sat_range(logic signed [15:0] hi, logic signed [15:0] lo);
		logic signed [16:0] d;
		d = 17'(hi) - 17'(lo);
		return (d > 17'sd32767) ? SAT15 : d[14:0];
	endfunction

	// effective window length
	always_comb begin
		eff_len = {1'b0, wlen_q};
		if (eff_len < LEN_W'(2)) eff_len = LEN_W'(2);
		if (eff_len > LEN_W'(MAX_WINDOW)) eff_len = LEN_W'(MAX_WINDOW);
	end

	assign busy = job_valid;
	assign take = start && !busy;
	assign first = cnt_q == '0;
	assign cnt_n = cnt_q + 1'b1;
	assign last = cnt_n >= eff_len;
	assign sum_n = sum_q + SUM_W'(sample.accel_z);

	// next extremes
	always_comb begin
		mnx_n = (first || sample.accel_x < mnx_q) ? sample.accel_x : mnx_q;
		mxx_n = (first || sample.accel_x > mxx_q) ? sample.accel_x : mxx_q;
		mny_n = (first || sample.accel_y < mny_q) ? sample.accel_y : mny_q;
		mxy_n = (first || sample.accel_y > mxy_q) ? sample.accel_y : mxy_q;
		mnz_n = (first || sample.accel_z < mnz_q) ? sample.accel_z : mnz_q;
		mxz_n = (first || sample.accel_z > mxz_q) ? sample.accel_z : mxz_q;
	end

	// z store write
	assign ram_we = take;
	assign ram_waddr = {wbank_q, cnt_q[AW-1:0]};
	assign ram_wdata = sample.accel_z;

	// window control and queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= 8'(WL_RESET);
			cnt_q <= '0;
			sum_q <= '0;
			wbank_q <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			if (job_valid && back_ready) begin
				job_valid <= 1'b0;
			end
			if (cfg_we) begin
				wlen_q <= cfg_data;
				cnt_q <= '0;
				sum_q <= '0;
			end else if (take) begin
				if (last) begin
					cnt_q <= '0;
					sum_q <= '0;
					wbank_q <= ~wbank_q;
					job_valid <= 1'b1;
				end else begin
					cnt_q <= cnt_n;
					sum_q <= sum_n;
				end
			end
		end
	end

	// extremes and queued job payload
	always_ff @(posedge clk) begin
		if (take) begin
			mnx_q <= mnx_n;
			mxx_q <= mxx_n;
			mny_q <= mny_n;
			mxy_q <= mxy_n;
			mnz_q <= mnz_n;
			mxz_q <= mxz_n;
			if (last) begin
				job.bank <= wbank_q;
				job.len <= eff_len;
				job.sum <= sum_n;
				job.min_y <= mny_n;
				job.range_x <= sat_range(mxx_n, mnx_n);
				job.range_y <= sat_range(mxy_n, mny_n);
				job.range_z <= sat_range(mxz_n, mnz_n);
			end
		end
	end

endmodule

@@ rtl/core/awsf_back.sv @@
// window finish: mean, deviation sweep over stored z, final divisions
// uses awsf_pkg, awsf_div
module awsf_back import awsf_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  job_t                        job,
	output logic                        ready,
	output logic [$clog2(MAX_WINDOW):0] ram_raddr,
	input  logic [15:0]                 ram_rdata,
	output result_t                     result,
	output logic                        result_valid
);

	localparam int AW = $clog2(MAX_WINDOW);

	typedef enum logic [2:0] {S_IDLE, S_MEAN, S_SWEEP, S_VAR, S_MAD} state_t;

	state_t             state_q;
	job_t               job_q;
	logic signed [16:0] mean_q;
	logic [LEN_W-1:0]   rd_cnt_q;
	logic               v1_q, v2_s2, v3_s3;
	logic [16:0]        ad_s2, ad_s3;
	logic [33:0]        sq_s3;
	logic [ACC_W-1:0]   sq_acc_q, ab_acc_q;
	logic               div_go_q;
	logic [ACC_W-1:0]   div_dvd_q;
	logic [LEN_W-1:0]   div_dsr_q;
	logic               div_done;
	logic [ACC_W-1:0]   div_quo;
	logic               issue, sweep_end;
	logic signed [17:0] dev;
	logic [SUM_W-1:0]   sum_mag;

	function automatic logic [14:0] sat_quo(logic [ACC_W-1:0] q);
		return (q > ACC_W'(32767)) ? SAT15 : q[14:0];
	endfunction

	awsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (div_dvd_q),
		.divisor  (div_dsr_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ready = state_q == S_IDLE;
	assign issue = (state_q == S_SWEEP) && (rd_cnt_q < job_q.len);
	assign sweep_end = (state_q == S_SWEEP) && !issue && !v1_q && !v2_s2 && !v3_s3;
	assign ram_raddr = {job_q.bank, rd_cnt_q[AW-1:0]};
	assign dev = 18'(signed'(ram_rdata)) - 18'(mean_q);
	assign sum_mag = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

	// control and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid <= 1'b0;
			div_go_q <= 1'b0;
			v1_q <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			div_go_q <= 1'b0;
			v1_q <= issue;
			v2_s2 <= v1_q;
			v3_s3 <= v2_s2;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						div_go_q <= 1'b1;
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (sweep_end) begin
						div_go_q <= 1'b1;
						state_q <= S_VAR;
					end
				end
				S_VAR: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q <= S_MAD;
					end
				end
				S_MAD: begin
					if (div_done) begin
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// deviation pipeline
		ad_s2 <= dev[17] ? 17'(-dev) : 17'(dev);
		ad_s3 <= ad_s2;
		sq_s3 <= ad_s2 * ad_s2;
		if (issue) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
		if (v3_s3) begin
			sq_acc_q <= sq_acc_q + ACC_W'(sq_s3);
			ab_acc_q <= ab_acc_q + ACC_W'(ad_s3);
		end
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					div_dvd_q <= ACC_W'(sum_mag);
					div_dsr_q <= job.len;
				end
			end
			S_MEAN: begin
				if (div_done) begin
					mean_q <= job_q.sum[SUM_W-1] ? 17'(-div_quo[16:0]) : div_quo[16:0];
					rd_cnt_q <= '0;
					sq_acc_q <= '0;
					ab_acc_q <= '0;
				end
			end
			S_SWEEP: begin
				if (sweep_end) begin
					div_dvd_q <= sq_acc_q;
					div_dsr_q <= job_q.len - 1'b1;
				end
			end
			S_VAR: begin
				if (div_done) begin
					result.variance_z <= sat_quo(div_quo);
					div_dvd_q <= ab_acc_q;
					div_dsr_q <= job_q.len;
				end
			end
			S_MAD: begin
				if (div_done) begin
					result.mean_abs_dev_z <= sat_quo(div_quo);
					result.min_y <= job_q.min_y;
					result.range_x <= job_q.range_x;
					result.range_y <= job_q.range_y;
					result.range_z <= job_q.range_z;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sim/tb_accel_window_stat_features.sv @@
// testbench for the accelerometer window statistics block
// depends on awsf_pkg and accel_window_stat_features; drives samples and checks each result
module tb_accel_window_stat_features import awsf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 256;
	localparam int DRAIN = 3 * 41 + MAXW + 40;
	localparam int WATCHDOG = 2000;

	logic clk, arst_n, start, busy, cfg_we, result_valid;
	sample_t sample;
	logic [7:0] cfg_data;
	result_t result;

	accel_window_stat_features dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result(result),
		.result_valid(result_valid)
	);

	// predictor state
	int unsigned win_len;
	int z_hist[MAXW];
	int unsigned fill;
	longint z_total;
	int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	result_t feature_q[$];

	int errors, mismatches, samples_sent, windows_seen, stall_pct, idle_cycles;

	// directed table: sample, plus a typed-in expectation where obvious
	typedef struct {
		logic [7:0] len;
		logic       set_len;
		sample_t    s;
		logic       has_exp;
		result_t    exp;
	} row_t;
	row_t dir_rows[$];

	function automatic longint sat15(longint v);
		if (v < 0) return 0;
		if (v > 32767) return 32767;
		return v;
	endfunction

	function automatic int unsigned eff_len(int unsigned n);
		if (n < 2) return 2;
		if (n > MAXW) return MAXW;
		return n;
	endfunction

	function automatic void clear_window();
		fill = 0;
		z_total = 0;
		lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
	endfunction

	// fold one sample in; queue the features when the window closes
	function automatic void predict_features(sample_t s);
		int x, y, z;
		int unsigned n;
		longint mean, sq, ab, d;
		result_t r;
		x = s.accel_x; y = s.accel_y; z = s.accel_z;
		n = eff_len(win_len);
		if (fill == 0) begin
			lo_x = x; hi_x = x; lo_y = y; hi_y = y; lo_z = z; hi_z = z;
		end else begin
			if (x < lo_x) lo_x = x;
			if (x > hi_x) hi_x = x;
			if (y < lo_y) lo_y = y;
			if (y > hi_y) hi_y = y;
			if (z < lo_z) lo_z = z;
			if (z > hi_z) hi_z = z;
		end
		z_hist[fill % MAXW] = z;
		z_total += z;
		fill++;
		if (fill < n) return;
		mean = z_total / longint'(n);
		sq = 0;
		ab = 0;
		for (int i = 0; i < n; i++) begin
			d = longint'(z_hist[i]) - mean;
			sq += d * d;
			ab += (d < 0) ? -d : d;
		end
		r.variance_z = 15'(sat15(sq / longint'(n - 1)));
		r.mean_abs_dev_z = 15'(sat15(ab / longint'(n)));
		r.min_y = 16'(lo_y);
		r.range_x = 15'(sat15(longint'(hi_x) - lo_x));
		r.range_y = 15'(sat15(longint'(hi_y) - lo_y));
		r.range_z = 15'(sat15(longint'(hi_z) - lo_z));
		feature_q.push_back(r);
		clear_window();
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			windows_seen++;
			if (feature_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result %p", result);
			end else begin
				result_t e;
				e = feature_q.pop_front();
				if (e !== result) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %p got %p", e, result);
				end
			end
		end
	end

	// watchdog on cycles without an accepted request or a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout waiting on the block");
			$display("tb_accel_window_stat_features: FAIL");
			$finish;
		end
	end

	// write the window length once everything is drained
	task automatic write_length(logic [7:0] v);
		wait_drained();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		win_len = v;
		clear_window();
	endtask

	task automatic wait_drained();
		start <= 0;
		while (feature_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// drive one request and hold it while busy, with random gaps before it
	task automatic send_sample(sample_t s);
		while (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		sample <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_features(s);
		samples_sent++;
	endtask

	function automatic sample_t rand_sample(int mode);
		sample_t s;
		s = sample_t'({$urandom, $urandom});
		if (mode == 1) begin
			s.accel_x = 16'($urandom_range(200, 0)) - 16'sd100;
			s.accel_y = 16'($urandom_range(200, 0)) - 16'sd100;
			s.accel_z = 16'($urandom_range(400, 0)) - 16'sd200;
		end
		return s;
	endfunction

	task automatic add_row(logic set, logic [7:0] l, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic he, result_t e);
		row_t r;
		r.set_len = set; r.len = l; r.has_exp = he; r.exp = e;
		r.s.accel_x = x; r.s.accel_y = y; r.s.accel_z = z;
		dir_rows.push_back(r);
	endtask

	initial begin
		result_t none, ext;
		int lens[6];
		lens = '{2, 3, 17, 1, 0, 255};
		start = 0; cfg_we = 0; cfg_data = 0; sample = '0;
		errors = 0; mismatches = 0; samples_sent = 0; windows_seen = 0;
		stall_pct = 0; idle_cycles = 0;
		win_len = WL_RESET;
		clear_window();
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows: extremes with length two give readable results
		none = '0;
		ext.variance_z = SAT15; ext.mean_abs_dev_z = SAT15; ext.min_y = -16'sd32768;
		ext.range_x = SAT15; ext.range_y = SAT15; ext.range_z = SAT15;
		add_row(1, 8'd2, -16'sd32768, -16'sd32768, -16'sd32768, 0, none);
		add_row(0, 0, 16'sd32767, 16'sd32767, 16'sd32767, 1, ext);
		ext = '0; ext.min_y = 16'sd5;
		add_row(0, 0, 16'sd7, 16'sd5, 16'sd9, 0, none);
		add_row(0, 0, 16'sd7, 16'sd5, 16'sd9, 1, ext);
		add_row(1, 8'd1, 16'sd0, -16'sd1, 16'sd1, 0, none);
		add_row(0, 0, 16'sd1, 16'sd0, -16'sd1, 0, none);
		add_row(1, 8'd0, 16'sd100, 16'sd3, -16'sd3, 0, none);
		add_row(0, 0, -16'sd100, 16'sd4, 16'sd3, 0, none);
		add_row(1, 8'd3, 16'sd1, 16'sd2, 16'sd3, 0, none);
		add_row(0, 0, -16'sd1, -16'sd2, -16'sd3, 0, none);
		add_row(1, 8'd3, 16'sd10, 16'sd10, 16'sd10, 0, none);
		add_row(0, 0, 16'sd11, 16'sd12, 16'sd13, 0, none);
		add_row(0, 0, 16'sd0, 16'sd0, 16'sd32767, 0, none);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_len) write_length(dir_rows[i].len);
			send_sample(dir_rows[i].s);
			if (dir_rows[i].has_exp && feature_q[$] !== dir_rows[i].exp) begin
				errors++;
				$display("table row %0d: predicted %p, typed %p", i,
					feature_q[$], dir_rows[i].exp);
			end
		end

		// reset-length window plus a partial window dropped by a write
		write_length(8'd64);
		repeat (64) send_sample(rand_sample(1));
		repeat (5) send_sample(rand_sample(0));

		// random phases across lengths and idling
		for (int ph = 0; ph < 12; ph++) begin
			int cnt;
			case (ph % 4)
				0: stall_pct = 0;
				1: stall_pct = 76;
				2: stall_pct = 15;
				default: stall_pct = 0;
			endcase
			write_length(ph < 6 ? 8'(lens[ph]) : 8'($urandom_range(12, 2)));
			cnt = (ph == 5) ? 255 : 47;
			for (int k = 0; k < cnt; k++)
				send_sample(rand_sample($urandom_range(1, 0)));
		end

		wait_drained();
		$display("sent %0d samples, checked %0d windows over lengths 0..255",
			samples_sent, windows_seen);
		if (errors == 0 && feature_q.size() == 0)
			$display("tb_accel_window_stat_features: PASS");
		else
			$display("tb_accel_window_stat_features: FAIL");
		$finish;
	end
endmodule
